// ===== design/assert_macros.svh =====
// assert_macros.svh
// Concurrent assertion macros shared by the design; no dependencies.
// Define ASSERT_OFF to compile the checks out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_CLK(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);
`define ASSERT_NEVER(label, clk, rstn, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) !(expr)) else $error(msg);
`else
`define ASSERT_CLK(label, clk, rstn, prop, msg)
`define ASSERT_NEVER(label, clk, rstn, expr, msg)
`endif
`endif

// ===== design/ila_pkg.sv =====
// ila_pkg.sv
// Field widths, fixed constants and shared types of the interval level aggregator.
// No dependencies.
package ila_pkg;

    localparam int TIME_BITS       = 32;
    localparam int SAMPLE_BITS     = 32;
    localparam int LEVEL_BITS      = 24;
    localparam int CODE_PORT_BITS  = 16;
    localparam int CLIP_BITS       = 48;
    localparam int CLIP_SUM_BITS   = 49;
    localparam int DEADLINE_BITS   = 33;
    localparam int SUM_BITS        = 40;
    localparam int CFG_BITS        = 24;
    localparam int PASS_BITS       = CLIP_SUM_BITS;
    localparam int BIT_CNT_BITS    = $clog2(PASS_BITS);

    localparam logic [CFG_BITS-1:0] DEFAULT_INTERVAL = CFG_BITS'(1000);

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

// ===== design/interval_level_aggregator.sv =====
// interval_level_aggregator.sv
// Top level: bit-serial snapshot pass, interval bookkeeping, output register.
// Depends on ila_pkg, ila_divider and assert_macros.svh.
// Each snapshot with samples runs an LSB-first bit-serial pass and a commit: a snapshot that
// closes no interval frees the input after the commit, one with zero samples skips the pass.
// A closing snapshot adds a serial division and a hold state: the point is loaded into the
// output register from the hold state, and the next snapshot is taken only after that load,
// later while the receiver still holds the previous point in the output register.
// aresetn (synchronous, active low) clears run, interval and output; interval set to 1000 ms.
module interval_level_aggregator
    import ila_pkg::*;
#(
    parameter int MAX_OBSERVATIONS = 65535,
    parameter int CODE_BITS        = 16
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      cfg_wr_en,
    input  logic [CFG_BITS-1:0]       cfg_wr_data,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic [TIME_BITS-1:0]      s_elapsed_time,
    input  logic [SAMPLE_BITS-1:0]    s_sample_tally,
    input  logic [LEVEL_BITS-1:0]     s_recent_level,
    input  logic [CODE_PORT_BITS-1:0] s_recent_low_code,
    input  logic [CODE_PORT_BITS-1:0] s_recent_high_code,
    input  logic [CLIP_BITS-1:0]      s_clip_low_total,
    input  logic [CLIP_BITS-1:0]      s_clip_high_total,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic [TIME_BITS-1:0]      m_point_time,
    output logic [LEVEL_BITS-1:0]     m_mean_level,
    output logic [CODE_PORT_BITS-1:0] m_interval_low_code,
    output logic [CODE_PORT_BITS-1:0] m_interval_high_code,
    output logic [CLIP_SUM_BITS-1:0]  m_clip_delta
);

`include "assert_macros.svh"

    localparam int CNT_BITS = $clog2(MAX_OBSERVATIONS + 1);
    localparam logic [CNT_BITS-1:0] CNT_MAX = CNT_BITS'(MAX_OBSERVATIONS);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_PASS   = 3'd1;
    localparam logic [2:0] ST_COMMIT = 3'd2;
    localparam logic [2:0] ST_DIV    = 3'd3;
    localparam logic [2:0] ST_HOLD   = 3'd4;

    logic [2:0]              state_reg, state_next;
    logic [BIT_CNT_BITS-1:0] bit_cnt_reg;
    logic [CFG_BITS-1:0]     interval_length_reg;

    // interval and run state
    logic                     run_started_reg;
    logic                     extremes_valid_reg;
    logic                     clip_valid_reg;
    logic [SUM_BITS-1:0]      level_sum_reg;
    logic [CNT_BITS-1:0]      observation_count_reg;
    logic [TIME_BITS-1:0]     prev_time_reg;
    logic [DEADLINE_BITS-1:0] deadline_reg;
    logic [CODE_BITS-1:0]     running_low_reg;
    logic [CODE_BITS-1:0]     running_high_reg;
    logic [CLIP_SUM_BITS-1:0] prev_clip_reg;

    // captured transaction
    logic [TIME_BITS-1:0]     time_reg;
    logic [LEVEL_BITS-1:0]    level_reg;
    logic [CODE_BITS-1:0]     lo_in_reg;
    logic [CODE_BITS-1:0]     hi_in_reg;

    // operand shift registers
    logic [TIME_BITS-1:0]     t_sr_reg;
    logic [TIME_BITS-1:0]     prev_sr_reg;
    logic [DEADLINE_BITS-1:0] dl_sr_reg;
    logic [CFG_BITS-1:0]      ivl_sr_reg;
    logic [SUM_BITS-1:0]      sum_sr_reg;
    logic [LEVEL_BITS-1:0]    lvl_sr_reg;
    logic [CLIP_BITS-1:0]     cl_lo_sr_reg;
    logic [CLIP_BITS-1:0]     cl_hi_sr_reg;
    logic [CLIP_SUM_BITS-1:0] pclip_sr_reg;

    // result shift registers
    logic [DEADLINE_BITS-1:0] tiv_res_reg;
    logic [DEADLINE_BITS-1:0] dadv_res_reg;
    logic [SUM_BITS-1:0]      sum_res_reg;
    logic [CLIP_SUM_BITS-1:0] clip_res_reg;
    logic [CLIP_SUM_BITS-1:0] delta_res_reg;

    // serial carries, borrows and compare flags
    logic c_tiv_reg, c_dadv_reg, c_sum_reg, c_clip_reg, bw_delta_reg;
    logic lt_back_reg, lt_dl_reg, lt_d2_reg;

    // pending point
    logic [TIME_BITS-1:0]     pend_time_reg;
    logic [CODE_BITS-1:0]     pend_low_reg;
    logic [CODE_BITS-1:0]     pend_high_reg;
    logic [CLIP_SUM_BITS-1:0] pend_delta_reg;

    // output register
    logic                      m_valid_reg;
    logic [TIME_BITS-1:0]      m_point_time_reg;
    logic [LEVEL_BITS-1:0]     m_mean_level_reg;
    logic [CODE_PORT_BITS-1:0] m_low_reg;
    logic [CODE_PORT_BITS-1:0] m_high_reg;
    logic [CLIP_SUM_BITS-1:0]  m_delta_reg;

    logic                  take, start_pass, in_pass, last_bit, in_commit, load_out;
    logic [CFG_BITS-1:0]   ivl_eff;
    logic                  tb, pb, db, ib, sb, lb, clb, chb, pcb;
    logic                  tiv_bit, d2_bit, sum_bit, clip_bit, delta_bit;

    logic                     back, fresh, emit, cnt_open, ext_keep;
    logic [SUM_BITS-1:0]      sum_sat, sum_upd;
    logic [CNT_BITS-1:0]      cnt_upd;
    logic [CODE_BITS-1:0]     low_upd, high_upd;
    logic [CLIP_SUM_BITS-1:0] delta_upd;
    logic [DEADLINE_BITS-1:0] dl_emit;

    logic                  div_start;
    logic [LEVEL_BITS-1:0] quotient;
    div_stat_t             div_stat;

    assign s_ready    = (state_reg == ST_IDLE);
    assign take       = s_valid && s_ready;
    assign start_pass = take && (s_sample_tally != '0);
    assign in_pass    = (state_reg == ST_PASS);
    assign last_bit   = (bit_cnt_reg == BIT_CNT_BITS'(PASS_BITS - 1));
    assign in_commit  = (state_reg == ST_COMMIT);
    assign load_out   = (state_reg == ST_HOLD) && (!m_valid_reg || m_ready);
    assign ivl_eff    = (interval_length_reg == '0) ? DEFAULT_INTERVAL : interval_length_reg;

    // serial datapath, one bit position per cycle
    assign tb  = t_sr_reg[0];
    assign pb  = prev_sr_reg[0];
    assign db  = dl_sr_reg[0];
    assign ib  = ivl_sr_reg[0];
    assign sb  = sum_sr_reg[0];
    assign lb  = lvl_sr_reg[0];
    assign clb = cl_lo_sr_reg[0];
    assign chb = cl_hi_sr_reg[0];
    assign pcb = pclip_sr_reg[0];

    assign tiv_bit   = tb ^ ib ^ c_tiv_reg;
    assign d2_bit    = db ^ ib ^ c_dadv_reg;
    assign sum_bit   = sb ^ lb ^ c_sum_reg;
    assign clip_bit  = clb ^ chb ^ c_clip_reg;
    assign delta_bit = clip_bit ^ pcb ^ bw_delta_reg;

    // commit decisions
    assign back      = run_started_reg && lt_back_reg;
    assign fresh     = !run_started_reg || back;
    assign emit      = !fresh && !lt_dl_reg;
    assign cnt_open  = (observation_count_reg < CNT_MAX);
    assign sum_sat   = c_sum_reg ? '1 : sum_res_reg;
    assign sum_upd   = back ? SUM_BITS'(level_reg)
                            : (cnt_open ? sum_sat : level_sum_reg);
    assign cnt_upd   = back ? CNT_BITS'(1)
                            : (cnt_open ? observation_count_reg + CNT_BITS'(1)
                                        : observation_count_reg);
    assign ext_keep  = extremes_valid_reg && !back;
    assign low_upd   = (!ext_keep || (lo_in_reg < running_low_reg)) ? lo_in_reg
                                                                    : running_low_reg;
    assign high_upd  = (!ext_keep || (hi_in_reg > running_high_reg)) ? hi_in_reg
                                                                     : running_high_reg;
    assign delta_upd = (clip_valid_reg && !bw_delta_reg) ? delta_res_reg : '0;
    assign dl_emit   = lt_d2_reg ? dadv_res_reg : tiv_res_reg;
    assign div_start = in_commit && emit;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (start_pass) begin
                    state_next = ST_PASS;
                end
            end
            ST_PASS: begin
                if (last_bit) begin
                    state_next = ST_COMMIT;
                end
            end
            ST_COMMIT: begin
                state_next = emit ? ST_DIV : ST_IDLE;
            end
            ST_DIV: begin
                if (div_stat.done) begin
                    state_next = ST_HOLD;
                end
            end
            ST_HOLD: begin
                if (load_out) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg             <= ST_IDLE;
            bit_cnt_reg           <= '0;
            interval_length_reg   <= DEFAULT_INTERVAL;
            run_started_reg       <= 1'b0;
            extremes_valid_reg    <= 1'b0;
            clip_valid_reg        <= 1'b0;
            level_sum_reg         <= '0;
            observation_count_reg <= '0;
            m_valid_reg           <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_wr_en) begin
                interval_length_reg <= cfg_wr_data;
            end
            if (start_pass) begin
                bit_cnt_reg <= '0;
            end else if (in_pass) begin
                bit_cnt_reg <= bit_cnt_reg + BIT_CNT_BITS'(1);
            end
            if (in_commit) begin
                run_started_reg       <= 1'b1;
                extremes_valid_reg    <= !emit;
                level_sum_reg         <= emit ? '0 : sum_upd;
                observation_count_reg <= emit ? '0 : cnt_upd;
                if (emit) begin
                    clip_valid_reg <= 1'b1;
                end else if (back) begin
                    clip_valid_reg <= 1'b0;
                end
            end
            if (load_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start_pass) begin
            time_reg     <= s_elapsed_time;
            level_reg    <= s_recent_level;
            lo_in_reg    <= CODE_BITS'(s_recent_low_code);
            hi_in_reg    <= CODE_BITS'(s_recent_high_code);
            t_sr_reg     <= s_elapsed_time;
            prev_sr_reg  <= prev_time_reg;
            dl_sr_reg    <= deadline_reg;
            ivl_sr_reg   <= ivl_eff;
            sum_sr_reg   <= level_sum_reg;
            lvl_sr_reg   <= s_recent_level;
            cl_lo_sr_reg <= s_clip_low_total;
            cl_hi_sr_reg <= s_clip_high_total;
            pclip_sr_reg <= prev_clip_reg;
            c_tiv_reg    <= 1'b0;
            c_dadv_reg   <= 1'b0;
            c_sum_reg    <= 1'b0;
            c_clip_reg   <= 1'b0;
            bw_delta_reg <= 1'b0;
            lt_back_reg  <= 1'b0;
            lt_dl_reg    <= 1'b0;
            lt_d2_reg    <= 1'b0;
        end else if (in_pass) begin
            t_sr_reg     <= {1'b0, t_sr_reg[TIME_BITS-1:1]};
            prev_sr_reg  <= {1'b0, prev_sr_reg[TIME_BITS-1:1]};
            dl_sr_reg    <= {1'b0, dl_sr_reg[DEADLINE_BITS-1:1]};
            ivl_sr_reg   <= {1'b0, ivl_sr_reg[CFG_BITS-1:1]};
            sum_sr_reg   <= {1'b0, sum_sr_reg[SUM_BITS-1:1]};
            lvl_sr_reg   <= {1'b0, lvl_sr_reg[LEVEL_BITS-1:1]};
            cl_lo_sr_reg <= {1'b0, cl_lo_sr_reg[CLIP_BITS-1:1]};
            cl_hi_sr_reg <= {1'b0, cl_hi_sr_reg[CLIP_BITS-1:1]};
            pclip_sr_reg <= {1'b0, pclip_sr_reg[CLIP_SUM_BITS-1:1]};
            c_tiv_reg    <= (tb & ib) | (tb & c_tiv_reg) | (ib & c_tiv_reg);
            c_dadv_reg   <= (db & ib) | (db & c_dadv_reg) | (ib & c_dadv_reg);
            c_clip_reg   <= (clb & chb) | (clb & c_clip_reg) | (chb & c_clip_reg);
            bw_delta_reg <= (!clip_bit & pcb) | (!(clip_bit ^ pcb) & bw_delta_reg);
            lt_back_reg  <= (!tb & pb) | (!(tb ^ pb) & lt_back_reg);
            lt_dl_reg    <= (!tb & db) | (!(tb ^ db) & lt_dl_reg);
            lt_d2_reg    <= (!tb & d2_bit) | (!(tb ^ d2_bit) & lt_d2_reg);
            // hold the sum carry-out once the sum width is done
            if (bit_cnt_reg < BIT_CNT_BITS'(SUM_BITS)) begin
                c_sum_reg   <= (sb & lb) | (sb & c_sum_reg) | (lb & c_sum_reg);
                sum_res_reg <= {sum_bit, sum_res_reg[SUM_BITS-1:1]};
            end
            if (bit_cnt_reg < BIT_CNT_BITS'(DEADLINE_BITS)) begin
                tiv_res_reg  <= {tiv_bit, tiv_res_reg[DEADLINE_BITS-1:1]};
                dadv_res_reg <= {d2_bit, dadv_res_reg[DEADLINE_BITS-1:1]};
            end
            clip_res_reg  <= {clip_bit, clip_res_reg[CLIP_SUM_BITS-1:1]};
            delta_res_reg <= {delta_bit, delta_res_reg[CLIP_SUM_BITS-1:1]};
        end
    end

    always_ff @(posedge aclk) begin
        if (in_commit) begin
            prev_time_reg    <= time_reg;
            running_low_reg  <= low_upd;
            running_high_reg <= high_upd;
            if (fresh) begin
                deadline_reg <= tiv_res_reg;
            end else if (emit) begin
                deadline_reg <= dl_emit;
            end
            if (emit) begin
                prev_clip_reg  <= clip_res_reg;
                pend_time_reg  <= time_reg;
                pend_low_reg   <= low_upd;
                pend_high_reg  <= high_upd;
                pend_delta_reg <= delta_upd;
            end else if (back) begin
                prev_clip_reg <= '0;
            end
        end
        if (load_out) begin
            m_point_time_reg <= pend_time_reg;
            m_mean_level_reg <= quotient;
            m_low_reg        <= CODE_PORT_BITS'(pend_low_reg);
            m_high_reg       <= CODE_PORT_BITS'(pend_high_reg);
            m_delta_reg      <= pend_delta_reg;
        end
    end

    ila_divider #(
        .DIVIDEND_BITS (SUM_BITS),
        .DIVISOR_BITS  (CNT_BITS),
        .QUOT_BITS     (LEVEL_BITS)
    ) u_divider (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (sum_upd),
        .divisor  (cnt_upd),
        .quotient (quotient),
        .stat     (div_stat)
    );

    assign m_valid              = m_valid_reg;
    assign m_point_time         = m_point_time_reg;
    assign m_mean_level         = m_mean_level_reg;
    assign m_interval_low_code  = m_low_reg;
    assign m_interval_high_code = m_high_reg;
    assign m_clip_delta         = m_delta_reg;

    `ASSERT_CLK(a_idle_div_quiet, aclk, aresetn, s_ready |-> !div_stat.busy, "divider busy while idle")
    `ASSERT_CLK(a_done_in_div, aclk, aresetn, div_stat.done |-> (state_reg == ST_DIV), "divider done outside division")
    `ASSERT_CLK(a_commit_after_pass, aclk, aresetn, in_commit |-> ($past(state_reg) == ST_PASS), "commit without a pass")
    `ASSERT_NEVER(a_count_bound, aclk, aresetn, observation_count_reg > CNT_MAX, "observation count above limit")

endmodule

// ===== design/ila_divider.sv =====
// ila_divider.sv
// Restoring divider, one quotient bit per cycle; keeps the low quotient bits.
// Depends on ila_pkg for the status type.
module ila_divider
    import ila_pkg::*;
#(
    parameter int DIVIDEND_BITS = 40,
    parameter int DIVISOR_BITS  = 16,
    parameter int QUOT_BITS     = 24
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     start,
    input  logic [DIVIDEND_BITS-1:0] dividend,
    input  logic [DIVISOR_BITS-1:0]  divisor,
    output logic [QUOT_BITS-1:0]     quotient,
    output div_stat_t                stat
);

    localparam int STEP_BITS = $clog2(DIVIDEND_BITS + 1);

    logic [DIVIDEND_BITS-1:0] dvd_reg;
    logic [DIVISOR_BITS-1:0]  dsr_reg;
    logic [DIVISOR_BITS-1:0]  rem_reg;
    logic [QUOT_BITS-1:0]     quot_reg;
    logic [STEP_BITS-1:0]     step_reg;
    logic                     busy_reg;
    logic                     done_reg;

    logic [DIVISOR_BITS:0]    trial;
    logic [DIVISOR_BITS:0]    diff;
    logic                     fits;
    logic [DIVISOR_BITS-1:0]  rem_next;

    assign trial    = {rem_reg, dvd_reg[DIVIDEND_BITS-1]};
    assign diff     = trial - {1'b0, dsr_reg};
    assign fits     = !diff[DIVISOR_BITS];
    assign rem_next = fits ? diff[DIVISOR_BITS-1:0] : trial[DIVISOR_BITS-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                step_reg <= STEP_BITS'(DIVIDEND_BITS);
            end else if (busy_reg) begin
                step_reg <= step_reg - STEP_BITS'(1);
                if (step_reg == STEP_BITS'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            dvd_reg  <= dividend;
            dsr_reg  <= divisor;
            rem_reg  <= '0;
            quot_reg <= '0;
        end else if (busy_reg) begin
            dvd_reg  <= {dvd_reg[DIVIDEND_BITS-2:0], 1'b0};
            rem_reg  <= rem_next;
            quot_reg <= {quot_reg[QUOT_BITS-2:0], fits};
        end
    end

    assign quotient  = quot_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

// ===== bench/interval_level_aggregator_tb.sv =====
// interval_level_aggregator_tb.sv
// Self-checking bench for interval_level_aggregator: directed and random snapshots, random
// stalls on both channels, interval points predicted in a small tracker class. Needs ila_pkg.
`timescale 1ns / 100ps

module interval_level_aggregator_tb;
    import ila_pkg::*;

    localparam int MAX_OBS         = 65535;
    localparam int PHASES          = 6;
    localparam int ITEMS_PER_PHASE = 200;
    localparam int HOLD_OFF_PHASE  = 3;
    localparam int HOLD_OFF_CYCLES = 1500;
    localparam int SETTLE_CYCLES   = 150;
    localparam int WATCHDOG_LIMIT  = 10000;

    typedef struct packed {
        logic [TIME_BITS-1:0]      elapsed_time;
        logic [SAMPLE_BITS-1:0]    sample_tally;
        logic [LEVEL_BITS-1:0]     recent_level;
        logic [CODE_PORT_BITS-1:0] recent_low_code;
        logic [CODE_PORT_BITS-1:0] recent_high_code;
        logic [CLIP_BITS-1:0]      clip_low_total;
        logic [CLIP_BITS-1:0]      clip_high_total;
    } snapshot_t;

    typedef struct packed {
        logic [TIME_BITS-1:0]      point_time;
        logic [LEVEL_BITS-1:0]     mean_level;
        logic [CODE_PORT_BITS-1:0] interval_low_code;
        logic [CODE_PORT_BITS-1:0] interval_high_code;
        logic [CLIP_SUM_BITS-1:0]  clip_delta;
    } point_t;

    class interval_tracker;
        logic [CFG_BITS-1:0]       interval_length;
        bit                        run_started;
        logic [TIME_BITS-1:0]      previous_time;
        logic [63:0]               deadline;
        logic [SUM_BITS-1:0]       level_sum;
        int unsigned               observation_count;
        bit                        extremes_valid;
        logic [CODE_PORT_BITS-1:0] running_low;
        logic [CODE_PORT_BITS-1:0] running_high;
        logic [CLIP_SUM_BITS-1:0]  previous_clip_total;
        bit                        clip_total_valid;
        point_t                    pending_points[$];
        int                        errors;

        function new();
            interval_length     = DEFAULT_INTERVAL;
            run_started         = 1'b0;
            previous_time       = '0;
            deadline            = '0;
            running_low         = '0;
            running_high        = '0;
            previous_clip_total = '0;
            clip_total_valid    = 1'b0;
            errors              = 0;
            clear_interval();
        endfunction

        function void clear_interval();
            level_sum         = '0;
            observation_count = 0;
            extremes_valid    = 1'b0;
        endfunction

        function void set_interval(logic [CFG_BITS-1:0] value);
            interval_length = value;
        endfunction

        function logic [63:0] interval_ms();
            return (interval_length == '0) ? 64'(DEFAULT_INTERVAL) : 64'(interval_length);
        endfunction

        function void note_snapshot(snapshot_t s);
            logic [63:0]              ivl;
            logic [63:0]              t;
            logic [CLIP_SUM_BITS-1:0] clip;
            logic [SUM_BITS:0]        widened;
            point_t                   p;
            if (s.sample_tally == '0)
                return;
            ivl  = interval_ms();
            t    = 64'(s.elapsed_time);
            clip = CLIP_SUM_BITS'(s.clip_low_total) + CLIP_SUM_BITS'(s.clip_high_total);
            if (run_started && s.elapsed_time < previous_time) begin
                clear_interval();
                previous_clip_total = '0;
                clip_total_valid    = 1'b0;
                run_started         = 1'b0;
            end
            previous_time = s.elapsed_time;
            if (!run_started) begin
                run_started = 1'b1;
                deadline    = t + ivl;
            end
            if (observation_count < MAX_OBS) begin
                widened   = {1'b0, level_sum} + s.recent_level;
                level_sum = widened[SUM_BITS] ? '1 : widened[SUM_BITS-1:0];
                observation_count++;
            end
            if (!extremes_valid) begin
                extremes_valid = 1'b1;
                running_low    = s.recent_low_code;
                running_high   = s.recent_high_code;
            end else begin
                if (s.recent_low_code < running_low)
                    running_low = s.recent_low_code;
                if (s.recent_high_code > running_high)
                    running_high = s.recent_high_code;
            end
            if (t < deadline)
                return;
            p.point_time         = s.elapsed_time;
            p.mean_level         = LEVEL_BITS'(level_sum / observation_count);
            p.interval_low_code  = running_low;
            p.interval_high_code = running_high;
            p.clip_delta         = (clip_total_valid && clip >= previous_clip_total) ?
                                   clip - previous_clip_total : '0;
            pending_points.push_back(p);
            previous_clip_total = clip;
            clip_total_valid    = 1'b1;
            clear_interval();
            deadline = deadline + ivl;
            if (deadline <= t)
                deadline = t + ivl;
        endfunction

        function void compare_field(string name, logic [63:0] want, logic [63:0] got);
            if (want !== got) begin
                $error("%s mismatch: expected %0h, actual %0h", name, want, got);
                errors++;
            end
        endfunction

        function void check_point(point_t got);
            point_t want;
            if (pending_points.size() == 0) begin
                $error("point with no snapshot behind it: point_time %0h", got.point_time);
                errors++;
                return;
            end
            want = pending_points.pop_front();
            compare_field("point_time", want.point_time, got.point_time);
            compare_field("mean_level", want.mean_level, got.mean_level);
            compare_field("interval_low_code", want.interval_low_code, got.interval_low_code);
            compare_field("interval_high_code", want.interval_high_code,
                          got.interval_high_code);
            compare_field("clip_delta", want.clip_delta, got.clip_delta);
        endfunction
    endclass

    logic                      aclk                 = 1'b0;
    logic                      aresetn              = 1'b0;
    logic                      cfg_wr_en            = 1'b0;
    logic [CFG_BITS-1:0]       cfg_wr_data          = '0;
    logic                      s_valid              = 1'b0;
    logic                      s_ready;
    logic [TIME_BITS-1:0]      s_elapsed_time       = '0;
    logic [SAMPLE_BITS-1:0]    s_sample_tally       = '0;
    logic [LEVEL_BITS-1:0]     s_recent_level       = '0;
    logic [CODE_PORT_BITS-1:0] s_recent_low_code    = '0;
    logic [CODE_PORT_BITS-1:0] s_recent_high_code   = '0;
    logic [CLIP_BITS-1:0]      s_clip_low_total     = '0;
    logic [CLIP_BITS-1:0]      s_clip_high_total    = '0;
    logic                      m_valid;
    logic                      m_ready              = 1'b0;
    logic [TIME_BITS-1:0]      m_point_time;
    logic [LEVEL_BITS-1:0]     m_mean_level;
    logic [CODE_PORT_BITS-1:0] m_interval_low_code;
    logic [CODE_PORT_BITS-1:0] m_interval_high_code;
    logic [CLIP_SUM_BITS-1:0]  m_clip_delta;

    interval_tracker           tracker              = new;
    bit                        quiet                = 1'b0;
    bit                        hold_off_pending     = 1'b0;
    int                        stalled_cycles       = 0;
    logic [TIME_BITS-1:0]      cur_time             = '0;
    logic [CLIP_BITS-1:0]      clip_low_run         = '0;
    logic [CLIP_BITS-1:0]      clip_high_run        = '0;
    logic [CFG_BITS-1:0]       interval_plan [PHASES] = '{24'd1, 24'hFFFFFF, 24'd0, 24'd37,
                                                          24'd1000, 24'd1};

    interval_level_aggregator u_top (
        .aclk                 (aclk),
        .aresetn              (aresetn),
        .cfg_wr_en            (cfg_wr_en),
        .cfg_wr_data          (cfg_wr_data),
        .s_valid              (s_valid),
        .s_ready              (s_ready),
        .s_elapsed_time       (s_elapsed_time),
        .s_sample_tally       (s_sample_tally),
        .s_recent_level       (s_recent_level),
        .s_recent_low_code    (s_recent_low_code),
        .s_recent_high_code   (s_recent_high_code),
        .s_clip_low_total     (s_clip_low_total),
        .s_clip_high_total    (s_clip_high_total),
        .m_valid              (m_valid),
        .m_ready              (m_ready),
        .m_point_time         (m_point_time),
        .m_mean_level         (m_mean_level),
        .m_interval_low_code  (m_interval_low_code),
        .m_interval_high_code (m_interval_high_code),
        .m_clip_delta         (m_clip_delta)
    );

    always #2 aclk = ~aclk;

    function automatic snapshot_t make_snapshot(logic [TIME_BITS-1:0] t,
                                                logic [SAMPLE_BITS-1:0] n,
                                                logic [LEVEL_BITS-1:0] lvl,
                                                logic [CODE_PORT_BITS-1:0] lo,
                                                logic [CODE_PORT_BITS-1:0] hi,
                                                logic [CLIP_BITS-1:0] clip_lo,
                                                logic [CLIP_BITS-1:0] clip_hi);
        return '{t, n, lvl, lo, hi, clip_lo, clip_hi};
    endfunction

    function automatic logic [CODE_PORT_BITS-1:0] random_code();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 10)
            return '0;
        if (pick < 20)
            return '1;
        return CODE_PORT_BITS'($urandom);
    endfunction

    function automatic logic [CLIP_BITS-1:0] next_clip_total(logic [CLIP_BITS-1:0] prev);
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 80)
            return prev + $urandom_range(0, 5000);
        if (pick < 90)
            return prev + CLIP_BITS'({$urandom, $urandom} >> $urandom_range(16, 40));
        if (pick < 96)
            return CLIP_BITS'({$urandom, $urandom});
        return (pick < 98) ? '1 : '0;
    endfunction

    function automatic snapshot_t random_snapshot();
        snapshot_t   s;
        logic [63:0] ivl;
        int unsigned pick;
        ivl  = tracker.interval_ms();
        pick = $urandom_range(0, 99);
        if (pick < 55)
            cur_time = cur_time + $urandom_range(0, 32'(ivl));
        else if (pick < 70)
            cur_time = (tracker.deadline <= 64'hFFFF_FFFF) ?
                       TIME_BITS'(tracker.deadline - $urandom_range(0, 1)) : $urandom;
        else if (pick < 78)
            cur_time = cur_time + TIME_BITS'(ivl * $urandom_range(2, 6) +
                                             $urandom_range(0, 32'(ivl)));
        else if (pick < 84)
            cur_time = $urandom_range(0, cur_time);
        else if (pick < 88)
            cur_time = $urandom;
        else if (pick < 91)
            cur_time = 32'hFFFF_FFFF - $urandom_range(0, 32'(ivl));
        s.elapsed_time = cur_time;

        pick = $urandom_range(0, 99);
        if (pick < 7)
            s.sample_tally = '0;
        else if (pick < 11)
            s.sample_tally = '1;
        else if (pick < 14)
            s.sample_tally = SAMPLE_BITS'(1);
        else
            s.sample_tally = $urandom_range(1, 32'hFFFF_FFFF);

        pick = $urandom_range(0, 99);
        if (pick < 10)
            s.recent_level = '0;
        else if (pick < 20)
            s.recent_level = '1;
        else
            s.recent_level = LEVEL_BITS'($urandom);

        s.recent_low_code  = random_code();
        s.recent_high_code = random_code();
        clip_low_run       = next_clip_total(clip_low_run);
        clip_high_run      = next_clip_total(clip_high_run);
        s.clip_low_total   = clip_low_run;
        s.clip_high_total  = clip_high_run;
        return s;
    endfunction

    task automatic send_snapshot(snapshot_t s);
        bit taken;
        int gap;
        gap = (quiet || $urandom_range(0, 3) != 0) ? 0 : $urandom_range(1, 19);
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid            <= 1'b1;
        s_elapsed_time     <= s.elapsed_time;
        s_sample_tally     <= s.sample_tally;
        s_recent_level     <= s.recent_level;
        s_recent_low_code  <= s.recent_low_code;
        s_recent_high_code <= s.recent_high_code;
        s_clip_low_total   <= s.clip_low_total;
        s_clip_high_total  <= s.clip_high_total;
        taken = 1'b0;
        while (!taken) begin
            @(negedge aclk);
            taken = s_ready;
            @(posedge aclk);
        end
        tracker.note_snapshot(s);
    endtask

    task automatic settle();
        s_valid <= 1'b0;
        while (tracker.pending_points.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_interval(logic [CFG_BITS-1:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        tracker.set_interval(value);
    endtask

    // result side: random ready bursts, one long hold-off on request, none at the end
    initial begin
        wait (aresetn === 1'b1);
        @(posedge aclk);
        forever begin
            if (hold_off_pending) begin
                m_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge aclk);
                hold_off_pending = 1'b0;
            end else if (quiet) begin
                m_ready <= 1'b1;
                @(posedge aclk);
            end else if ($urandom_range(0, 7) == 0) begin
                m_ready <= 1'b1;
                repeat ($urandom_range(40, 120)) @(posedge aclk);
            end else begin
                m_ready <= ($urandom_range(0, 2) != 0);
                repeat ($urandom_range(1, 19)) @(posedge aclk);
            end
        end
    end

    always @(negedge aclk) begin
        if (aresetn && m_valid && m_ready)
            tracker.check_point({m_point_time, m_mean_level, m_interval_low_code,
                                 m_interval_high_code, m_clip_delta});
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            stalled_cycles = 0;
        end else begin
            stalled_cycles = stalled_cycles + 1;
            if (stalled_cycles >= WATCHDOG_LIMIT) begin
                $display("interval_level_aggregator_tb: done, errors");
                $finish;
            end
        end
    end

    initial begin
        snapshot_t item;
        int        taken;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // default interval of 1000 ms straight out of reset
        send_snapshot(make_snapshot(32'd0, 32'd1, '0, '1, '0, '0, '0));
        send_snapshot(make_snapshot(32'd5, 32'd0, '1, '0, '1, '1, '1));
        send_snapshot(make_snapshot(32'd500, '1, '1, '0, '1, 48'd100, 48'd200));
        send_snapshot(make_snapshot(32'd1000, 32'd7, 24'h123456, 16'h8000, 16'h8000,
                                    48'd1000, 48'd2000));
        send_snapshot(make_snapshot(32'd1999, 32'd3, 24'h80, 16'h1234, 16'h4321,
                                    48'd5000, 48'd0));
        send_snapshot(make_snapshot(32'd2000, 32'd3, 24'h100, 16'h10, 16'h20, '1, '1));
        send_snapshot(make_snapshot(32'd10000, 32'd1, 24'h1, 16'h5, 16'h6, 48'd10, 48'd10));
        send_snapshot(make_snapshot(32'd10999, 32'd2, 24'h7FFFFF, 16'h7FFF, 16'h7FFF,
                                    48'd30, 48'd40));
        send_snapshot(make_snapshot(32'd11000, 32'd9, 24'h800000, 16'hFFFE, 16'h0001,
                                    48'd30, 48'd70));
        send_snapshot(make_snapshot(32'd3, 32'd4, 24'h55AA55, 16'h00FF, 16'hFF00,
                                    48'd50, 48'd60));
        send_snapshot(make_snapshot(32'd3, 32'd4, 24'hAA55AA, 16'hFF00, 16'h00FF,
                                    48'd60, 48'd70));
        send_snapshot(make_snapshot(32'd1003, 32'd1, 24'h10, 16'h100, 16'h200,
                                    48'd80, 48'd90));
        send_snapshot(make_snapshot('1, 32'd2, '1, '1, '1, 48'd100, 48'd100));
        send_snapshot(make_snapshot('1, 32'd5, '0, '0, '0, 48'd200, 48'd200));
        send_snapshot(make_snapshot(32'd0, 32'd0, 24'h123, 16'h1, 16'h2, '0, '0));
        send_snapshot(make_snapshot(32'd0, 32'd5, 24'h456, 16'h3, 16'h4, '0, '0));

        interval_plan[PHASES-1] = CFG_BITS'($urandom_range(2, 5000));
        for (int phase = 0; phase < PHASES; phase++) begin
            settle();
            write_interval(interval_plan[phase]);
            if (phase == HOLD_OFF_PHASE)
                hold_off_pending = 1'b1;
            taken = 0;
            while (taken < ITEMS_PER_PHASE) begin
                if (phase == PHASES - 1 && taken >= ITEMS_PER_PHASE / 2)
                    quiet = 1'b1;
                item = random_snapshot();
                send_snapshot(item);
                if (item.sample_tally != '0)
                    taken++;
            end
        end
        settle();

        if (tracker.errors == 0)
            $display("interval_level_aggregator_tb: done, clean");
        else
            $display("interval_level_aggregator_tb: done, errors");
        $finish;
    end

endmodule
